/* design/des_pkg.sv */
// DES shared package: stage record type, permutation and S-box tables,
// and the wiring functions built on them.
// No dependencies; used by des_round and des_block_cipher.
`default_nettype none

package des_pkg;

  // One pipeline slot: control bits, key halves after PC-1, data halves.
  typedef struct packed {
    logic        vld;
    logic        dec;
    logic [27:0] c;
    logic [27:0] d;
    logic [31:0] l;
    logic [31:0] r;
  } des_stage_t;

  localparam int NUM_ROUNDS = 16;

  // Tables use 1-based bit numbers counted from the MSB.
  localparam logic [6:0] PC1_TBL [56] = '{
    7'd57, 7'd49, 7'd41, 7'd33, 7'd25, 7'd17, 7'd9,  7'd1,  7'd58, 7'd50, 7'd42, 7'd34, 7'd26, 7'd18,
    7'd10, 7'd2,  7'd59, 7'd51, 7'd43, 7'd35, 7'd27, 7'd19, 7'd11, 7'd3,  7'd60, 7'd52, 7'd44, 7'd36,
    7'd63, 7'd55, 7'd47, 7'd39, 7'd31, 7'd23, 7'd15, 7'd7,  7'd62, 7'd54, 7'd46, 7'd38, 7'd30, 7'd22,
    7'd14, 7'd6,  7'd61, 7'd53, 7'd45, 7'd37, 7'd29, 7'd21, 7'd13, 7'd5,  7'd28, 7'd20, 7'd12, 7'd4
  };

  localparam logic [5:0] PC2_TBL [48] = '{
    6'd14, 6'd17, 6'd11, 6'd24, 6'd1,  6'd5,  6'd3,  6'd28, 6'd15, 6'd6,  6'd21, 6'd10,
    6'd23, 6'd19, 6'd12, 6'd4,  6'd26, 6'd8,  6'd16, 6'd7,  6'd27, 6'd20, 6'd13, 6'd2,
    6'd41, 6'd52, 6'd31, 6'd37, 6'd47, 6'd55, 6'd30, 6'd40, 6'd51, 6'd45, 6'd33, 6'd48,
    6'd44, 6'd49, 6'd39, 6'd56, 6'd34, 6'd53, 6'd46, 6'd42, 6'd50, 6'd36, 6'd29, 6'd32
  };

  localparam logic [1:0] ROT_TBL [16] = '{
    2'd1, 2'd1, 2'd2, 2'd2, 2'd2, 2'd2, 2'd2, 2'd2,
    2'd1, 2'd2, 2'd2, 2'd2, 2'd2, 2'd2, 2'd2, 2'd1
  };

  localparam logic [6:0] IP_TBL [64] = '{
    7'd58, 7'd50, 7'd42, 7'd34, 7'd26, 7'd18, 7'd10, 7'd2,
    7'd60, 7'd52, 7'd44, 7'd36, 7'd28, 7'd20, 7'd12, 7'd4,
    7'd62, 7'd54, 7'd46, 7'd38, 7'd30, 7'd22, 7'd14, 7'd6,
    7'd64, 7'd56, 7'd48, 7'd40, 7'd32, 7'd24, 7'd16, 7'd8,
    7'd57, 7'd49, 7'd41, 7'd33, 7'd25, 7'd17, 7'd9,  7'd1,
    7'd59, 7'd51, 7'd43, 7'd35, 7'd27, 7'd19, 7'd11, 7'd3,
    7'd61, 7'd53, 7'd45, 7'd37, 7'd29, 7'd21, 7'd13, 7'd5,
    7'd63, 7'd55, 7'd47, 7'd39, 7'd31, 7'd23, 7'd15, 7'd7
  };

  localparam logic [6:0] FP_TBL [64] = '{
    7'd40, 7'd8, 7'd48, 7'd16, 7'd56, 7'd24, 7'd64, 7'd32,
    7'd39, 7'd7, 7'd47, 7'd15, 7'd55, 7'd23, 7'd63, 7'd31,
    7'd38, 7'd6, 7'd46, 7'd14, 7'd54, 7'd22, 7'd62, 7'd30,
    7'd37, 7'd5, 7'd45, 7'd13, 7'd53, 7'd21, 7'd61, 7'd29,
    7'd36, 7'd4, 7'd44, 7'd12, 7'd52, 7'd20, 7'd60, 7'd28,
    7'd35, 7'd3, 7'd43, 7'd11, 7'd51, 7'd19, 7'd59, 7'd27,
    7'd34, 7'd2, 7'd42, 7'd10, 7'd50, 7'd18, 7'd58, 7'd26,
    7'd33, 7'd1, 7'd41, 7'd9,  7'd49, 7'd17, 7'd57, 7'd25
  };

  localparam logic [5:0] E_TBL [48] = '{
    6'd32, 6'd1,  6'd2,  6'd3,  6'd4,  6'd5,  6'd4,  6'd5,  6'd6,  6'd7,  6'd8,  6'd9,
    6'd8,  6'd9,  6'd10, 6'd11, 6'd12, 6'd13, 6'd12, 6'd13, 6'd14, 6'd15, 6'd16, 6'd17,
    6'd16, 6'd17, 6'd18, 6'd19, 6'd20, 6'd21, 6'd20, 6'd21, 6'd22, 6'd23, 6'd24, 6'd25,
    6'd24, 6'd25, 6'd26, 6'd27, 6'd28, 6'd29, 6'd28, 6'd29, 6'd30, 6'd31, 6'd32, 6'd1
  };

  localparam logic [5:0] P_TBL [32] = '{
    6'd16, 6'd7,  6'd20, 6'd21, 6'd29, 6'd12, 6'd28, 6'd17,
    6'd1,  6'd15, 6'd23, 6'd26, 6'd5,  6'd18, 6'd31, 6'd10,
    6'd2,  6'd8,  6'd24, 6'd14, 6'd32, 6'd27, 6'd3,  6'd9,
    6'd19, 6'd13, 6'd30, 6'd6,  6'd22, 6'd11, 6'd4,  6'd25
  };

  localparam logic [3:0] SBOX_TBL [8][64] = '{
    '{4'd14, 4'd4, 4'd13, 4'd1, 4'd2, 4'd15, 4'd11, 4'd8, 4'd3, 4'd10, 4'd6, 4'd12, 4'd5, 4'd9,
      4'd0, 4'd7, 4'd0, 4'd15, 4'd7, 4'd4, 4'd14, 4'd2, 4'd13, 4'd1, 4'd10, 4'd6, 4'd12, 4'd11,
      4'd9, 4'd5, 4'd3, 4'd8, 4'd4, 4'd1, 4'd14, 4'd8, 4'd13, 4'd6, 4'd2, 4'd11, 4'd15, 4'd12,
      4'd9, 4'd7, 4'd3, 4'd10, 4'd5, 4'd0, 4'd15, 4'd12, 4'd8, 4'd2, 4'd4, 4'd9, 4'd1, 4'd7,
      4'd5, 4'd11, 4'd3, 4'd14, 4'd10, 4'd0, 4'd6, 4'd13},
    '{4'd15, 4'd1, 4'd8, 4'd14, 4'd6, 4'd11, 4'd3, 4'd4, 4'd9, 4'd7, 4'd2, 4'd13, 4'd12, 4'd0,
      4'd5, 4'd10, 4'd3, 4'd13, 4'd4, 4'd7, 4'd15, 4'd2, 4'd8, 4'd14, 4'd12, 4'd0, 4'd1, 4'd10,
      4'd6, 4'd9, 4'd11, 4'd5, 4'd0, 4'd14, 4'd7, 4'd11, 4'd10, 4'd4, 4'd13, 4'd1, 4'd5, 4'd8,
      4'd12, 4'd6, 4'd9, 4'd3, 4'd2, 4'd15, 4'd13, 4'd8, 4'd10, 4'd1, 4'd3, 4'd15, 4'd4, 4'd2,
      4'd11, 4'd6, 4'd7, 4'd12, 4'd0, 4'd5, 4'd14, 4'd9},
    '{4'd10, 4'd0, 4'd9, 4'd14, 4'd6, 4'd3, 4'd15, 4'd5, 4'd1, 4'd13, 4'd12, 4'd7, 4'd11, 4'd4,
      4'd2, 4'd8, 4'd13, 4'd7, 4'd0, 4'd9, 4'd3, 4'd4, 4'd6, 4'd10, 4'd2, 4'd8, 4'd5, 4'd14,
      4'd12, 4'd11, 4'd15, 4'd1, 4'd13, 4'd6, 4'd4, 4'd9, 4'd8, 4'd15, 4'd3, 4'd0, 4'd11, 4'd1,
      4'd2, 4'd12, 4'd5, 4'd10, 4'd14, 4'd7, 4'd1, 4'd10, 4'd13, 4'd0, 4'd6, 4'd9, 4'd8, 4'd7,
      4'd4, 4'd15, 4'd14, 4'd3, 4'd11, 4'd5, 4'd2, 4'd12},
    '{4'd7, 4'd13, 4'd14, 4'd3, 4'd0, 4'd6, 4'd9, 4'd10, 4'd1, 4'd2, 4'd8, 4'd5, 4'd11, 4'd12,
      4'd4, 4'd15, 4'd13, 4'd8, 4'd11, 4'd5, 4'd6, 4'd15, 4'd0, 4'd3, 4'd4, 4'd7, 4'd2, 4'd12,
      4'd1, 4'd10, 4'd14, 4'd9, 4'd10, 4'd6, 4'd9, 4'd0, 4'd12, 4'd11, 4'd7, 4'd13, 4'd15, 4'd1,
      4'd3, 4'd14, 4'd5, 4'd2, 4'd8, 4'd4, 4'd3, 4'd15, 4'd0, 4'd6, 4'd10, 4'd1, 4'd13, 4'd8,
      4'd9, 4'd4, 4'd5, 4'd11, 4'd12, 4'd7, 4'd2, 4'd14},
    '{4'd2, 4'd12, 4'd4, 4'd1, 4'd7, 4'd10, 4'd11, 4'd6, 4'd8, 4'd5, 4'd3, 4'd15, 4'd13, 4'd0,
      4'd14, 4'd9, 4'd14, 4'd11, 4'd2, 4'd12, 4'd4, 4'd7, 4'd13, 4'd1, 4'd5, 4'd0, 4'd15, 4'd10,
      4'd3, 4'd9, 4'd8, 4'd6, 4'd4, 4'd2, 4'd1, 4'd11, 4'd10, 4'd13, 4'd7, 4'd8, 4'd15, 4'd9,
      4'd12, 4'd5, 4'd6, 4'd3, 4'd0, 4'd14, 4'd11, 4'd8, 4'd12, 4'd7, 4'd1, 4'd14, 4'd2, 4'd13,
      4'd6, 4'd15, 4'd0, 4'd9, 4'd10, 4'd4, 4'd5, 4'd3},
    '{4'd12, 4'd1, 4'd10, 4'd15, 4'd9, 4'd2, 4'd6, 4'd8, 4'd0, 4'd13, 4'd3, 4'd4, 4'd14, 4'd7,
      4'd5, 4'd11, 4'd10, 4'd15, 4'd4, 4'd2, 4'd7, 4'd12, 4'd9, 4'd5, 4'd6, 4'd1, 4'd13, 4'd14,
      4'd0, 4'd11, 4'd3, 4'd8, 4'd9, 4'd14, 4'd15, 4'd5, 4'd2, 4'd8, 4'd12, 4'd3, 4'd7, 4'd0,
      4'd4, 4'd10, 4'd1, 4'd13, 4'd11, 4'd6, 4'd4, 4'd3, 4'd2, 4'd12, 4'd9, 4'd5, 4'd15, 4'd10,
      4'd11, 4'd14, 4'd1, 4'd7, 4'd6, 4'd0, 4'd8, 4'd13},
    '{4'd4, 4'd11, 4'd2, 4'd14, 4'd15, 4'd0, 4'd8, 4'd13, 4'd3, 4'd12, 4'd9, 4'd7, 4'd5, 4'd10,
      4'd6, 4'd1, 4'd13, 4'd0, 4'd11, 4'd7, 4'd4, 4'd9, 4'd1, 4'd10, 4'd14, 4'd3, 4'd5, 4'd12,
      4'd2, 4'd15, 4'd8, 4'd6, 4'd1, 4'd4, 4'd11, 4'd13, 4'd12, 4'd3, 4'd7, 4'd14, 4'd10, 4'd15,
      4'd6, 4'd8, 4'd0, 4'd5, 4'd9, 4'd2, 4'd6, 4'd11, 4'd13, 4'd8, 4'd1, 4'd4, 4'd10, 4'd7,
      4'd9, 4'd5, 4'd0, 4'd15, 4'd14, 4'd2, 4'd3, 4'd12},
    '{4'd13, 4'd2, 4'd8, 4'd4, 4'd6, 4'd15, 4'd11, 4'd1, 4'd10, 4'd9, 4'd3, 4'd14, 4'd5, 4'd0,
      4'd12, 4'd7, 4'd1, 4'd15, 4'd13, 4'd8, 4'd10, 4'd3, 4'd7, 4'd4, 4'd12, 4'd5, 4'd6, 4'd11,
      4'd0, 4'd14, 4'd9, 4'd2, 4'd7, 4'd11, 4'd4, 4'd1, 4'd9, 4'd12, 4'd14, 4'd2, 4'd0, 4'd6,
      4'd10, 4'd13, 4'd15, 4'd3, 4'd5, 4'd8, 4'd2, 4'd1, 4'd14, 4'd7, 4'd4, 4'd10, 4'd8, 4'd13,
      4'd15, 4'd12, 4'd9, 4'd0, 4'd3, 4'd5, 4'd6, 4'd11}
  };

  // Total left rotation of C and D after round idx (0-based); 28 wraps to identity.
  function automatic logic [4:0] cum_shift(input int idx);
    logic [4:0] s;
    s = 5'd0;
    for (int i = 0; i < NUM_ROUNDS; i++) begin
      if (i <= idx) s = s + 5'(ROT_TBL[i]);
    end
    return s;
  endfunction

  function automatic logic [27:0] rotl28(input logic [27:0] v, input logic [4:0] s);
    logic [55:0] w;
    w = {v, v} << s;
    return w[55:28];
  endfunction

  function automatic logic [55:0] pc1_perm(input logic [63:0] v);
    logic [55:0] r;
    for (int i = 0; i < 56; i++) r[6'(55 - i)] = v[6'(7'd64 - PC1_TBL[i])];
    return r;
  endfunction

  function automatic logic [47:0] pc2_perm(input logic [55:0] v);
    logic [47:0] r;
    for (int i = 0; i < 48; i++) r[6'(47 - i)] = v[6'(6'd56 - PC2_TBL[i])];
    return r;
  endfunction

  function automatic logic [63:0] ip_perm(input logic [63:0] v);
    logic [63:0] r;
    for (int i = 0; i < 64; i++) r[6'(63 - i)] = v[6'(7'd64 - IP_TBL[i])];
    return r;
  endfunction

  function automatic logic [63:0] fp_perm(input logic [63:0] v);
    logic [63:0] r;
    for (int i = 0; i < 64; i++) r[6'(63 - i)] = v[6'(7'd64 - FP_TBL[i])];
    return r;
  endfunction

  function automatic logic [47:0] e_expand(input logic [31:0] v);
    logic [47:0] r;
    for (int i = 0; i < 48; i++) r[6'(47 - i)] = v[5'(6'd32 - E_TBL[i])];
    return r;
  endfunction

  function automatic logic [31:0] p_perm(input logic [31:0] v);
    logic [31:0] r;
    for (int i = 0; i < 32; i++) r[5'(31 - i)] = v[5'(6'd32 - P_TBL[i])];
    return r;
  endfunction

  // Eight parallel S-box lookups; row from the outer bits, column from the inner four.
  function automatic logic [31:0] sbox_sub(input logic [47:0] x);
    logic [31:0] s;
    logic [5:0]  b;
    for (int i = 0; i < 8; i++) begin
      b = x[47 - 6 * i -: 6];
      s[31 - 4 * i -: 4] = SBOX_TBL[i][{b[5], b[0], b[4:1]}];
    end
    return s;
  endfunction

endpackage

`default_nettype wire

/* design/des_block_cipher.sv */
// DES ECB engine top: key registers on an APB-style port, input stage, 16 round stages
// and the result register. Depends on des_pkg and des_round.
// A request passes the input register, one register per round and the result register
// in that order; one request per cycle, busy stays low.
// The result strobe lasts one cycle and cannot be held off by the receiver.
// Reset (synchronous, active low) clears both keys and all pipeline valid bits.
`default_nettype none

module des_block_cipher
  import des_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst_n,
  // request channel
  input  wire logic        start,
  output logic             busy,
  input  wire logic        in_op,
  input  wire logic        in_key_select,
  input  wire logic [63:0] in_data_block,
  // result channel
  output logic             out_strobe,
  output logic [63:0]      out_result_block,
  // configuration port
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [3:0]  paddr,
  input  wire logic [63:0] pwdata,
  output logic [63:0]      prdata,
  output logic             pready
);

  // Register index is address bit 3 (registers sit 8 bytes apart).
  localparam logic REG_FIRST_KEY  = 1'b0;
  localparam logic REG_SECOND_KEY = 1'b1;

  logic        accept;
  logic        cfg_wr;
  logic [63:0] first_key_r;
  logic [63:0] second_key_r;
  logic [63:0] key_sel;
  logic [55:0] cd_in;
  logic [63:0] ip_in;
  logic        out_strobe_r;
  logic [63:0] out_result_block_r;
  des_stage_t  stg0_r;

  // stg[0] is the input register; stg[k] holds the state after round k.
  des_stage_t stg [NUM_ROUNDS + 1];

  // Nothing ever stalls the pipe.
  assign busy   = 1'b0;
  assign accept = start && !busy;
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready;

  // ---------------- key registers ----------------
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      first_key_r  <= 64'd0;
      second_key_r <= 64'd0;
    end else if (cfg_wr) begin
      unique case (paddr[3])
        REG_FIRST_KEY:  first_key_r  <= pwdata;
        REG_SECOND_KEY: second_key_r <= pwdata;
        default:        ;
      endcase
    end
  end

  always_comb begin
    unique case (paddr[3])
      REG_FIRST_KEY:  prdata = first_key_r;
      REG_SECOND_KEY: prdata = second_key_r;
      default:        prdata = 64'd0;
    endcase
  end

  // ---------------- input stage ----------------
  // PC-1 and IP are pure wiring; the key mux is the only logic here.
  assign key_sel = in_key_select ? second_key_r : first_key_r;
  assign cd_in   = pc1_perm(key_sel);
  assign ip_in   = ip_perm(in_data_block);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      stg0_r.vld <= 1'b0;
    end else begin
      stg0_r.vld <= accept;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      stg0_r.dec <= in_op;
      stg0_r.c   <= cd_in[55:28];
      stg0_r.d   <= cd_in[27:0];
      stg0_r.l   <= ip_in[63:32];
      stg0_r.r   <= ip_in[31:0];
    end
  end

  assign stg[0] = stg0_r;

  // ---------------- round stages ----------------
  // Each stage carries the unrotated C/D halves and rotates by its own fixed amount
  // for encryption or for decryption, so the key schedule costs no extra registers.
  for (genvar g = 0; g < NUM_ROUNDS; g++) begin : g_round
    des_round #(
      .ROUND (g)
    ) u_round (
      .clk     (clk),
      .rst_n   (rst_n),
      .stg_in  (stg[g]),
      .stg_out (stg[g + 1])
    );
  end

  // ---------------- result register ----------------
  // Halves swap after the last round, then the final permutation.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_strobe_r <= 1'b0;
    end else begin
      out_strobe_r <= stg[NUM_ROUNDS].vld;
    end
  end

  always_ff @(posedge clk) begin
    out_result_block_r <= fp_perm({stg[NUM_ROUNDS].r, stg[NUM_ROUNDS].l});
  end

  assign out_strobe       = out_strobe_r;
  assign out_result_block = out_result_block_r;

  // ---------------- assertions ----------------
  // Every accepted request yields a result strobe through the input, round and result registers.
  a_req_to_result: assert property (@(posedge clk) disable iff (!rst_n)
    accept |-> ##18 out_strobe)
    else $error("accepted request produced no result on time");

  // No result appears without a matching earlier request.
  a_no_spurious: assert property (@(posedge clk) disable iff (!rst_n)
    !accept |-> ##18 !out_strobe)
    else $error("result strobe without a matching request");

  // Keys change only on a completed configuration write.
  a_key1_hold: assert property (@(posedge clk) disable iff (!rst_n)
    !cfg_wr |=> $stable(first_key_r))
    else $error("first key changed without a write");

  a_key2_hold: assert property (@(posedge clk) disable iff (!rst_n)
    !cfg_wr |=> $stable(second_key_r))
    else $error("second key changed without a write");

endmodule

`default_nettype wire

/* design/des_round.sv */
// DES round stage: one Feistel round with its subkey, then a pipeline register.
// Depends on des_pkg (stage type, PC-2, E, S-box and P functions).
`default_nettype none

module des_round
  import des_pkg::*;
#(
  parameter int ROUND = 0
) (
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire des_stage_t stg_in,
  output des_stage_t      stg_out
);

  // Encryption uses subkey ROUND, decryption subkey 15-ROUND.
  localparam logic [4:0] ENC_SH = cum_shift(ROUND);
  localparam logic [4:0] DEC_SH = cum_shift(NUM_ROUNDS - 1 - ROUND);

  logic [4:0]  sh;
  logic [47:0] subkey;
  logic [31:0] f_out;
  des_stage_t  stg_r;
  des_stage_t  stg_nxt;

  assign sh     = stg_in.dec ? DEC_SH : ENC_SH;
  assign subkey = pc2_perm({rotl28(stg_in.c, sh), rotl28(stg_in.d, sh)});
  assign f_out  = p_perm(sbox_sub(e_expand(stg_in.r) ^ subkey));

  always_comb begin
    stg_nxt   = stg_in;
    stg_nxt.l = stg_in.r;
    stg_nxt.r = stg_in.l ^ f_out;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      stg_r.vld <= 1'b0;
    end else begin
      stg_r.vld <= stg_nxt.vld;
    end
  end

  always_ff @(posedge clk) begin
    stg_r.dec <= stg_nxt.dec;
    stg_r.c   <= stg_nxt.c;
    stg_r.d   <= stg_nxt.d;
    stg_r.l   <= stg_nxt.l;
    stg_r.r   <= stg_nxt.r;
  end

  assign stg_out = stg_r;

endmodule

`default_nettype wire
